>>> design/icsolv_pkg.sv
package icsolv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIVW      = 32 + FRAC_BITS;
    localparam int DCNTW     = $clog2(DIVW + 1);
    localparam int PCW       = 6;

    localparam logic [PCW-1:0] PC_NEWTON = 6'd0;
    localparam logic [PCW-1:0] PC_FIXED  = 6'd26;
    localparam logic [PCW-1:0] PC_STEP   = 6'd1;

    localparam logic [30:0] TIME_STEP_RST  = 31'd6554;
    localparam logic [30:0] SPACE_STEP_RST = 31'd6554;
    localparam logic [30:0] TOLERANCE_RST  = 31'd66;
    localparam logic [11:0] ITER_LIMIT_RST = 12'd100;

    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_TIME_STEP  = 3'd0,
        REG_SPACE_STEP = 3'd1,
        REG_TOLERANCE  = 3'd2,
        REG_ITER_LIMIT = 3'd3,
        REG_METHOD     = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_TSTZ = 3'd4,
        OP_FIN  = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        SRC_T   = 4'd0,
        SRC_A   = 4'd1,
        SRC_B   = 4'd2,
        SRC_C   = 4'd3,
        SRC_T1  = 4'd4,
        SRC_Y   = 4'd5,
        SRC_X   = 4'd6,
        SRC_G   = 4'd7,
        SRC_D1  = 4'd8,
        SRC_D2  = 4'd9,
        SRC_Q   = 4'd10,
        SRC_QD  = 4'd11,
        SRC_N   = 4'd12,
        SRC_TAU = 4'd13,
        SRC_H   = 4'd14,
        SRC_ONE = 4'd15
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t dst;
        src_t sa;
        src_t sb;
    } instr_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_CHECK = 3'd1,
        ST_ISSUE = 3'd2,
        ST_MUL   = 3'd3,
        ST_DIV   = 3'd4
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'(Q_MAX))
                r = Q_MAX;
            else if (v < 66'(Q_MIN))
                r = Q_MIN;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    function automatic instr_t prog_at(input logic [PCW-1:0] pc);
        instr_t i;
        begin
            case (pc)
                6'd0:  i = '{OP_SUB,  SRC_X,  SRC_C,   SRC_A};
                6'd1:  i = '{OP_ADD,  SRC_X,  SRC_X,   SRC_Y};
                6'd2:  i = '{OP_SUB,  SRC_D1, SRC_X,   SRC_B};
                6'd3:  i = '{OP_ADD,  SRC_X,  SRC_T1,  SRC_Y};
                6'd4:  i = '{OP_MUL,  SRC_G,  SRC_Y,   SRC_X};
                6'd5:  i = '{OP_ADD,  SRC_X,  SRC_T1,  SRC_C};
                6'd6:  i = '{OP_MUL,  SRC_X,  SRC_C,   SRC_X};
                6'd7:  i = '{OP_SUB,  SRC_D2, SRC_G,   SRC_X};
                6'd8:  i = '{OP_ADD,  SRC_X,  SRC_T,   SRC_B};
                6'd9:  i = '{OP_MUL,  SRC_X,  SRC_B,   SRC_X};
                6'd10: i = '{OP_ADD,  SRC_D2, SRC_D2,  SRC_X};
                6'd11: i = '{OP_ADD,  SRC_X,  SRC_T,   SRC_A};
                6'd12: i = '{OP_MUL,  SRC_X,  SRC_A,   SRC_X};
                6'd13: i = '{OP_SUB,  SRC_D2, SRC_D2,  SRC_X};
                6'd14: i = '{OP_DIV,  SRC_X,  SRC_D1,  SRC_TAU};
                6'd15: i = '{OP_DIV,  SRC_G,  SRC_D2,  SRC_H};
                6'd16: i = '{OP_SUB,  SRC_Q,  SRC_X,   SRC_G};
                6'd17: i = '{OP_DIV,  SRC_X,  SRC_ONE, SRC_TAU};
                6'd18: i = '{OP_ADD,  SRC_G,  SRC_Y,   SRC_Y};
                6'd19: i = '{OP_ADD,  SRC_G,  SRC_G,   SRC_T1};
                6'd20: i = '{OP_DIV,  SRC_G,  SRC_G,   SRC_H};
                6'd21: i = '{OP_SUB,  SRC_QD, SRC_X,   SRC_G};
                6'd22: i = '{OP_TSTZ, SRC_QD, SRC_QD,  SRC_QD};
                6'd23: i = '{OP_DIV,  SRC_X,  SRC_Q,   SRC_QD};
                6'd24: i = '{OP_SUB,  SRC_N,  SRC_Y,   SRC_X};
                6'd25: i = '{OP_FIN,  SRC_N,  SRC_N,   SRC_Y};
                6'd26: i = '{OP_DIV,  SRC_X,  SRC_TAU, SRC_H};
                6'd27: i = '{OP_ADD,  SRC_G,  SRC_Y,   SRC_C};
                6'd28: i = '{OP_ADD,  SRC_G,  SRC_G,   SRC_T1};
                6'd29: i = '{OP_MUL,  SRC_G,  SRC_X,   SRC_G};
                6'd30: i = '{OP_SUB,  SRC_Q,  SRC_Y,   SRC_C};
                6'd31: i = '{OP_MUL,  SRC_Q,  SRC_G,   SRC_Q};
                6'd32: i = '{OP_ADD,  SRC_D1, SRC_B,   SRC_A};
                6'd33: i = '{OP_ADD,  SRC_D2, SRC_D1,  SRC_T};
                6'd34: i = '{OP_MUL,  SRC_D2, SRC_X,   SRC_D2};
                6'd35: i = '{OP_SUB,  SRC_G,  SRC_B,   SRC_A};
                6'd36: i = '{OP_MUL,  SRC_D2, SRC_D2,  SRC_G};
                6'd37: i = '{OP_SUB,  SRC_G,  SRC_D1,  SRC_C};
                6'd38: i = '{OP_ADD,  SRC_G,  SRC_G,   SRC_Q};
                6'd39: i = '{OP_ADD,  SRC_N,  SRC_G,   SRC_D2};
                default: i = '{OP_FIN, SRC_N, SRC_N,   SRC_Y};
            endcase
            return i;
        end
    endfunction

endpackage

>>> design/icsolv_alu.sv
module icsolv_alu (
    input  logic                clk,
    input  icsolv_pkg::op_t     op,
    input  logic signed [31:0]  opa,
    input  logic signed [31:0]  opb,
    output logic signed [31:0]  addsub_res,
    output logic signed [31:0]  mul_res
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] rounded;
    logic signed [63:0] shifted;

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
    end

    always_comb
    begin
        if (op == icsolv_pkg::OP_SUB)
            addsub_res = icsolv_pkg::sat32(66'(opa) - 66'(opb));
        else
            addsub_res = icsolv_pkg::sat32(66'(opa) + 66'(opb));
    end

    assign rounded = prod_reg + (64'sd1 <<< (icsolv_pkg::FRAC_BITS - 1));
    assign shifted = rounded >>> icsolv_pkg::FRAC_BITS;
    assign mul_res = icsolv_pkg::sat32(66'(shifted));

endmodule

>>> design/icsolv_div.sv
module icsolv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [31:0]            dividend,
    input  logic signed [31:0]            divisor,
    output logic                          done,
    output logic signed [31:0]            quotient
);

    localparam int DW = icsolv_pkg::DIVW;
    localparam int CW = icsolv_pkg::DCNTW;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [32:0]   rem_reg;
    logic [DW-1:0] quo_reg;
    logic [31:0]   den_reg;
    logic          neg_reg;

    logic [31:0]   mag_a;
    logic [31:0]   mag_b;
    logic [32:0]   trial;
    logic          fits;

    assign mag_a = dividend[31] ? 32'(-dividend) : 32'(dividend);
    assign mag_b = divisor[31] ? 32'(-divisor) : 32'(divisor);
    assign trial = {rem_reg[31:0], quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= {mag_a, {icsolv_pkg::FRAC_BITS{1'b0}}};
            den_reg <= mag_b;
            neg_reg <= dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > DW'(33'h1_0000_0000 >> 1))
                quotient = icsolv_pkg::Q_MIN;
            else
                quotient = -$signed(quo_reg[31:0]);
        end
        else
        begin
            if (quo_reg > DW'(32'h7FFF_FFFF))
                quotient = icsolv_pkg::Q_MAX;
            else
                quotient = $signed(quo_reg[31:0]);
        end
    end

    assign done = done_reg;

endmodule

>>> design/implicit_pde_cell_solver.sv
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------
// item in   | start, busy           | time_now, left_old, right_old, left_new
// item out  | done (one-cycle)      | new_value, iterations_used, failed
// config    | psel/penable/pwrite   | paddr, pwdata, prdata, pready (always high)
//
// One item takes a data-dependent number of cycles, set by the Newton or
// fixed-point iteration count, the shared serial divider and the sequencer, which
// issues one operation per cycle except while it waits on a multiply or a divide.
// busy is high from acceptance until the result strobe; done rises with busy low.
// Asynchronous active-low reset loads the register defaults and idles the sequencer.
// The receiver cannot stall: done is high for one cycle; the result is held.
module implicit_pde_cell_solver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] time_now,
    input  logic signed [31:0] left_old,
    input  logic signed [31:0] right_old,
    input  logic signed [31:0] left_new,
    output logic               done,
    output logic signed [31:0] new_value,
    output logic [11:0]        iterations_used,
    output logic               failed,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    icsolv_pkg::state_t state_reg, state_next;

    logic [30:0] tau_reg;
    logic [30:0] h_reg;
    logic [30:0] tol_reg;
    logic [11:0] limit_reg;
    logic        method_reg;

    logic signed [31:0] t_reg, a_reg, b_reg, c_reg, t1_reg, y_reg;
    logic signed [31:0] x_reg, g_reg, d1_reg, d2_reg, q_reg, qd_reg, n_reg;
    logic [icsolv_pkg::PCW-1:0] pc_reg, pc_next;
    logic [11:0] cnt_reg;

    logic               done_reg;
    logic signed [31:0] val_reg;
    logic [11:0]        iter_reg;
    logic               fail_reg;

    icsolv_pkg::instr_t instr;
    logic signed [31:0] opa, opb;
    logic signed [31:0] addsub_res, mul_res, div_res;
    logic               div_start;
    logic               div_done;

    logic               wr_en;
    logic signed [31:0] wr_val;
    logic               fin_en;
    logic               fin_fail;
    logic               fin_conv;
    logic               step_en;
    logic signed [32:0] diff;
    logic [32:0]        diff_abs;
    logic               accept;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    function automatic logic signed [31:0] pick(
        input icsolv_pkg::src_t s,
        input logic signed [31:0] vt, input logic signed [31:0] va,
        input logic signed [31:0] vb, input logic signed [31:0] vc,
        input logic signed [31:0] vt1, input logic signed [31:0] vy,
        input logic signed [31:0] vx, input logic signed [31:0] vg,
        input logic signed [31:0] vd1, input logic signed [31:0] vd2,
        input logic signed [31:0] vq, input logic signed [31:0] vqd,
        input logic signed [31:0] vn, input logic [30:0] vtau,
        input logic [30:0] vh);
        logic signed [31:0] r;
        begin
            case (s)
                icsolv_pkg::SRC_T:   r = vt;
                icsolv_pkg::SRC_A:   r = va;
                icsolv_pkg::SRC_B:   r = vb;
                icsolv_pkg::SRC_C:   r = vc;
                icsolv_pkg::SRC_T1:  r = vt1;
                icsolv_pkg::SRC_Y:   r = vy;
                icsolv_pkg::SRC_X:   r = vx;
                icsolv_pkg::SRC_G:   r = vg;
                icsolv_pkg::SRC_D1:  r = vd1;
                icsolv_pkg::SRC_D2:  r = vd2;
                icsolv_pkg::SRC_Q:   r = vq;
                icsolv_pkg::SRC_QD:  r = vqd;
                icsolv_pkg::SRC_N:   r = vn;
                icsolv_pkg::SRC_TAU: r = $signed({1'b0, vtau});
                icsolv_pkg::SRC_H:   r = $signed({1'b0, vh});
                icsolv_pkg::SRC_ONE: r = icsolv_pkg::Q_ONE;
                default:             r = vy;
            endcase
            return r;
        end
    endfunction

    assign instr = icsolv_pkg::prog_at(pc_reg);
    assign opa = pick(instr.sa, t_reg, a_reg, b_reg, c_reg, t1_reg, y_reg, x_reg,
                      g_reg, d1_reg, d2_reg, q_reg, qd_reg, n_reg, tau_reg, h_reg);
    assign opb = pick(instr.sb, t_reg, a_reg, b_reg, c_reg, t1_reg, y_reg, x_reg,
                      g_reg, d1_reg, d2_reg, q_reg, qd_reg, n_reg, tau_reg, h_reg);

    icsolv_alu u_alu (
        .clk        (clk),
        .op         (instr.op),
        .opa        (opa),
        .opb        (opb),
        .addsub_res (addsub_res),
        .mul_res    (mul_res)
    );

    icsolv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opa),
        .divisor  (opb),
        .done     (div_done),
        .quotient (div_res)
    );

    assign accept   = start && (state_reg == icsolv_pkg::ST_IDLE);
    assign diff     = 33'(n_reg) - 33'(y_reg);
    assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= icsolv_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        wr_en       = 1'b0;
        wr_val      = addsub_res;
        fin_en      = 1'b0;
        fin_fail    = 1'b1;
        fin_conv    = 1'b0;
        step_en     = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            icsolv_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = icsolv_pkg::ST_CHECK;
            end
            icsolv_pkg::ST_CHECK:
            begin
                if (cnt_reg >= limit_reg)
                    fin_en = 1'b1;
                else if (!method_reg)
                begin
                    if (tau_reg == '0 || h_reg == '0)
                        fin_en = 1'b1;
                    else
                    begin
                        pc_next    = icsolv_pkg::PC_NEWTON;
                        state_next = icsolv_pkg::ST_ISSUE;
                    end
                end
                else if (h_reg == '0)
                    fin_en = 1'b1;
                else
                begin
                    pc_next    = icsolv_pkg::PC_FIXED;
                    state_next = icsolv_pkg::ST_ISSUE;
                end
            end
            icsolv_pkg::ST_ISSUE:
            begin
                case (instr.op)
                    icsolv_pkg::OP_ADD, icsolv_pkg::OP_SUB:
                    begin
                        wr_en   = 1'b1;
                        pc_next = pc_reg + icsolv_pkg::PC_STEP;
                    end
                    icsolv_pkg::OP_MUL:
                        state_next = icsolv_pkg::ST_MUL;
                    icsolv_pkg::OP_DIV:
                    begin
                        div_start  = 1'b1;
                        state_next = icsolv_pkg::ST_DIV;
                    end
                    icsolv_pkg::OP_TSTZ:
                    begin
                        if (qd_reg == '0)
                            fin_en = 1'b1;
                        else
                            pc_next = pc_reg + icsolv_pkg::PC_STEP;
                    end
                    icsolv_pkg::OP_FIN:
                    begin
                        step_en = 1'b1;
                        if (diff_abs <= 33'(tol_reg))
                        begin
                            fin_en   = 1'b1;
                            fin_fail = 1'b0;
                            fin_conv = 1'b1;
                        end
                        else
                            state_next = icsolv_pkg::ST_CHECK;
                    end
                    default:
                        state_next = icsolv_pkg::ST_CHECK;
                endcase
            end
            icsolv_pkg::ST_MUL:
            begin
                wr_en      = 1'b1;
                wr_val     = mul_res;
                pc_next    = pc_reg + icsolv_pkg::PC_STEP;
                state_next = icsolv_pkg::ST_ISSUE;
            end
            icsolv_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    wr_val     = div_res;
                    pc_next    = pc_reg + icsolv_pkg::PC_STEP;
                    state_next = icsolv_pkg::ST_ISSUE;
                end
            end
            default:
                state_next = icsolv_pkg::ST_IDLE;
        endcase
        if (fin_en)
            state_next = icsolv_pkg::ST_IDLE;
    end

    always_ff @(posedge clk)
    begin
        pc_reg <= pc_next;
        if (accept)
        begin
            t_reg  <= time_now;
            a_reg  <= left_old;
            b_reg  <= right_old;
            c_reg  <= left_new;
            t1_reg <= icsolv_pkg::sat32(66'(time_now) + 66'(tau_reg));
            y_reg  <= 32'((33'(right_old) + 33'(left_new)) >>> 1);
            cnt_reg <= '0;
        end
        else if (step_en)
        begin
            y_reg   <= n_reg;
            cnt_reg <= cnt_reg + 12'd1;
        end
        if (wr_en)
        begin
            case (instr.dst)
                icsolv_pkg::SRC_X:  x_reg  <= wr_val;
                icsolv_pkg::SRC_G:  g_reg  <= wr_val;
                icsolv_pkg::SRC_D1: d1_reg <= wr_val;
                icsolv_pkg::SRC_D2: d2_reg <= wr_val;
                icsolv_pkg::SRC_Q:  q_reg  <= wr_val;
                icsolv_pkg::SRC_QD: qd_reg <= wr_val;
                icsolv_pkg::SRC_N:  n_reg  <= wr_val;
                default:            x_reg  <= x_reg;
            endcase
        end
        if (fin_en)
        begin
            val_reg  <= fin_conv ? n_reg : y_reg;
            iter_reg <= fin_conv ? (cnt_reg + 12'd1) : cnt_reg;
            fail_reg <= fin_fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fin_en;
    end

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg    <= icsolv_pkg::TIME_STEP_RST;
            h_reg      <= icsolv_pkg::SPACE_STEP_RST;
            tol_reg    <= icsolv_pkg::TOLERANCE_RST;
            limit_reg  <= icsolv_pkg::ITER_LIMIT_RST;
            method_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                icsolv_pkg::REG_TIME_STEP:  tau_reg    <= pwdata[30:0];
                icsolv_pkg::REG_SPACE_STEP: h_reg      <= pwdata[30:0];
                icsolv_pkg::REG_TOLERANCE:  tol_reg    <= pwdata[30:0];
                icsolv_pkg::REG_ITER_LIMIT: limit_reg  <= pwdata[11:0];
                icsolv_pkg::REG_METHOD:     method_reg <= pwdata[0];
                default:                    method_reg <= method_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            icsolv_pkg::REG_TIME_STEP:  prdata = {1'b0, tau_reg};
            icsolv_pkg::REG_SPACE_STEP: prdata = {1'b0, h_reg};
            icsolv_pkg::REG_TOLERANCE:  prdata = {1'b0, tol_reg};
            icsolv_pkg::REG_ITER_LIMIT: prdata = {20'd0, limit_reg};
            icsolv_pkg::REG_METHOD:     prdata = {31'd0, method_reg};
            default:                    prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign busy            = (state_reg != icsolv_pkg::ST_IDLE);
    assign done            = done_reg;
    assign new_value       = val_reg;
    assign iterations_used = iter_reg;
    assign failed          = fail_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result strobe while busy");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("item accepted but not busy");
    a_iter_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (iterations_used <= limit_reg)) else $error("iteration count over limit");
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == icsolv_pkg::ST_DIV)) else $error("stray divider result");
`endif

endmodule
